### rtl/sobel_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the Sobel edge threshold block.
// Depends on nothing; every other file of the block but sobel_fifo uses it.
package sobel_pkg;

  localparam int unsigned PIX_W = 8;
  localparam int unsigned THR_W = 11;
  localparam int unsigned DIM_W = 10;
  localparam int unsigned CFG_IDX_W = 2;

  localparam int unsigned MAX_WIDTH_DEF = 512;
  localparam int unsigned MAX_HEIGHT_DEF = 512;
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned MIN_DIM = 3;

  localparam logic [THR_W-1:0] THR_RESET = 11'd80;
  localparam logic [DIM_W-1:0] WIDTH_RESET = 10'd512;
  localparam logic [DIM_W-1:0] HEIGHT_RESET = 10'd512;

  localparam logic [PIX_W-1:0] PIX_EDGE = 8'd255;
  localparam logic [PIX_W-1:0] PIX_FLAT = 8'd0;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_THRESHOLD = 2'd0,
    CFG_WIDTH     = 2'd1,
    CFG_HEIGHT    = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic             is_flush;
    logic             emit;
    logic             compute;
    logic             sel_mid;
    logic             last;
    logic [PIX_W-1:0] pixel;
  } cmd_t;

endpackage

### rtl/sobel_front.sv
`timescale 1ns / 1ps
// Front end: accepts pixels and flush transactions, tracks frame positions
// and turns each useful transaction into a command for the queue. Uses sobel_pkg.
module sobel_front #(
  parameter int unsigned MAX_WIDTH  = sobel_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = sobel_pkg::MAX_HEIGHT_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [sobel_pkg::PIX_W-1:0]    in_pixel_i,
  input  logic                           in_flush_i,
  input  logic [sobel_pkg::DIM_W-1:0]    width_i,
  input  logic [sobel_pkg::DIM_W-1:0]    height_i,
  input  logic                           full_i,
  output logic                           push_o,
  output sobel_pkg::cmd_t                push_cmd_o,
  output logic [$clog2(MAX_WIDTH)-1:0]   push_k_o,
  output logic [$clog2(MAX_WIDTH)-1:0]   push_oaddr_o
);
  import sobel_pkg::*;

  localparam int unsigned CW = $clog2(MAX_WIDTH);
  localparam int unsigned WW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned RW = $clog2(MAX_HEIGHT);
  localparam int unsigned HW = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned FW = $clog2(MAX_WIDTH + 2);

  logic [CW-1:0] in_col_q, in_col_d, out_col_q, out_col_d, cur_oc;
  logic [RW-1:0] in_row_q, in_row_d, out_row_q, out_row_d, cur_or;
  logic [FW-1:0] fill_q, fill_d, fill_full;
  logic [WW-1:0] w, wm1, wm2;
  logic [HW-1:0] h, hm1, hm2;
  logic          accept, at_start, emit;
  cmd_t          cmd;

  always_comb begin
    if (width_i < DIM_W'(MIN_DIM)) begin
      w = WW'(MIN_DIM);
    end else if (32'(width_i) > MAX_WIDTH) begin
      w = WW'(MAX_WIDTH);
    end else begin
      w = WW'(width_i);
    end
    if (height_i < DIM_W'(MIN_DIM)) begin
      h = HW'(MIN_DIM);
    end else if (32'(height_i) > MAX_HEIGHT) begin
      h = HW'(MAX_HEIGHT);
    end else begin
      h = HW'(height_i);
    end
  end

  assign wm1 = w - WW'(1);
  assign wm2 = w - WW'(2);
  assign hm1 = h - HW'(1);
  assign hm2 = h - HW'(2);
  assign fill_full = FW'(w) + FW'(1);

  assign in_ready_o = !full_i;
  assign accept = in_valid_i && !full_i;
  assign at_start = (in_col_q == '0) && (in_row_q == '0);

  always_comb begin
    in_col_d = in_col_q;
    in_row_d = in_row_q;
    out_col_d = out_col_q;
    out_row_d = out_row_q;
    fill_d = fill_q;
    push_o = 1'b0;
    emit = 1'b0;
    cmd = '0;
    cur_oc = out_col_q;
    cur_or = out_row_q;
    if (accept) begin
      if (in_flush_i) begin
        if (fill_q != '0 && at_start) begin
          push_o = 1'b1;
          emit = 1'b1;
          cmd.is_flush = 1'b1;
          cmd.sel_mid = (out_row_q >= hm1);
          fill_d = fill_q - FW'(1);
        end
      end else begin
        push_o = 1'b1;
        cmd.pixel = in_pixel_i;
        if (at_start && fill_q != '0 && fill_q < fill_full) begin
          fill_d = '0;
          cur_oc = '0;
          cur_or = '0;
        end
        if (in_col_q >= wm1) begin
          in_col_d = '0;
          in_row_d = (in_row_q >= hm1) ? '0 : in_row_q + RW'(1);
        end else begin
          in_col_d = in_col_q + CW'(1);
        end
        if (fill_d < fill_full) begin
          fill_d = fill_d + FW'(1);
        end else begin
          emit = 1'b1;
          cmd.compute = (cur_or != '0) && (cur_or <= hm2)
                        && (cur_oc != '0) && (cur_oc <= wm2);
        end
      end
      out_col_d = cur_oc;
      out_row_d = cur_or;
      if (emit) begin
        cmd.emit = 1'b1;
        cmd.last = (cur_or >= hm1) && (cur_oc >= wm1);
        if (cmd.last) begin
          out_col_d = '0;
          out_row_d = '0;
        end else if (cur_oc >= wm1) begin
          out_col_d = '0;
          out_row_d = cur_or + RW'(1);
        end else begin
          out_col_d = cur_oc + CW'(1);
        end
      end
    end
  end

  assign push_cmd_o = cmd;
  assign push_k_o = in_col_q;
  assign push_oaddr_o = cur_oc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_col_q <= '0;
      in_row_q <= '0;
      out_col_q <= '0;
      out_row_q <= '0;
      fill_q <= '0;
    end else begin
      in_col_q <= in_col_d;
      in_row_q <= in_row_d;
      out_col_q <= out_col_d;
      out_row_q <= out_row_d;
      fill_q <= fill_d;
    end
  end

endmodule

### rtl/sobel_fifo.sv
`timescale 1ns / 1ps
// Short command queue between the front end and the datapath.
// Generic width and depth; uses no package content.
module sobel_fifo #(
  parameter int unsigned DATA_W = 8,
  parameter int unsigned DEPTH  = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  logic [DATA_W-1:0] data_i,
  input  logic              pop_i,
  output logic [DATA_W-1:0] data_o,
  output logic              empty_o,
  output logic              full_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned NW = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [PW-1:0]     wr_ptr_q, rd_ptr_q;
  logic [NW-1:0]     count_q;
  logic              do_push, do_pop;

  assign empty_o = (count_q == '0);
  assign full_o = (count_q == NW'(DEPTH));
  assign do_push = push_i && !full_o;
  assign do_pop = pop_i && !empty_o;
  assign data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + NW'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - NW'(1);
      end
    end
  end

endmodule

### rtl/sobel_back.sv
`timescale 1ns / 1ps
// Datapath: line buffers, 3x3 window, Sobel gradient and threshold,
// and the output register. Uses sobel_pkg.
module sobel_back #(
  parameter int unsigned MAX_WIDTH = sobel_pkg::MAX_WIDTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [sobel_pkg::THR_W-1:0]   threshold_i,
  input  logic                          empty_i,
  output logic                          pop_o,
  input  sobel_pkg::cmd_t               head_cmd_i,
  input  logic [$clog2(MAX_WIDTH)-1:0]  head_k_i,
  input  logic [$clog2(MAX_WIDTH)-1:0]  head_oaddr_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [sobel_pkg::PIX_W-1:0]   out_pixel_o,
  output logic                          out_last_o
);
  import sobel_pkg::*;

  localparam int unsigned CW = $clog2(MAX_WIDTH);

  logic [PIX_W-1:0] upper_mem [MAX_WIDTH];
  logic [PIX_W-1:0] middle_mem [MAX_WIDTH];

  logic             adv, wr_en;
  logic [CW-1:0]    mid_addr;
  logic             s1_valid_q, s2_valid_q, out_valid_q;
  cmd_t             s1_cmd_q;
  logic [CW-1:0]    s1_k_q, s1_oaddr_q;
  logic [PIX_W-1:0] rd_up_k_q, rd_up_o_q, rd_mid_q;
  logic [PIX_W-1:0] border;
  logic [PIX_W-1:0] win_q [9];
  logic             s2_emit_q, s2_compute_q, s2_last_q;
  logic [PIX_W-1:0] s2_border_q;
  logic [9:0]       gx_pos, gx_neg, gy_pos, gy_neg;
  logic [10:0]      gx, gy;
  logic [9:0]       gx_abs, gy_abs;
  logic [10:0]      mag;
  logic             is_edge;
  logic [PIX_W-1:0] out_pixel_q;
  logic             out_last_q;

  assign adv = !out_valid_q || out_ready_i;
  assign pop_o = adv && !empty_i;
  assign wr_en = adv && s1_valid_q && !s1_cmd_q.is_flush;
  assign mid_addr = head_cmd_i.is_flush ? head_oaddr_i : head_k_i;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      upper_mem[s1_k_q] <= rd_mid_q;
      middle_mem[s1_k_q] <= s1_cmd_q.pixel;
    end
    if (pop_o) begin
      rd_up_k_q <= (wr_en && s1_k_q == head_k_i) ? rd_mid_q : upper_mem[head_k_i];
      rd_up_o_q <= (wr_en && s1_k_q == head_oaddr_i) ? rd_mid_q : upper_mem[head_oaddr_i];
      rd_mid_q <= (wr_en && s1_k_q == mid_addr) ? s1_cmd_q.pixel : middle_mem[mid_addr];
      s1_cmd_q <= head_cmd_i;
      s1_k_q <= head_k_i;
      s1_oaddr_q <= head_oaddr_i;
    end
  end

  always_comb begin
    if (s1_cmd_q.is_flush) begin
      border = s1_cmd_q.sel_mid ? rd_mid_q : rd_up_o_q;
    end else begin
      border = (s1_oaddr_q == s1_k_q) ? rd_mid_q : rd_up_o_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s2_emit_q <= s1_cmd_q.emit;
      s2_compute_q <= s1_cmd_q.compute;
      s2_last_q <= s1_cmd_q.last;
      s2_border_q <= border;
      out_pixel_q <= s2_compute_q ? (is_edge ? PIX_EDGE : PIX_FLAT) : s2_border_q;
      out_last_q <= s2_last_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < 9; i++) begin
        win_q[i] <= '0;
      end
    end else begin
      if (adv) begin
        s1_valid_q <= !empty_i;
        s2_valid_q <= s1_valid_q;
        out_valid_q <= s2_valid_q && s2_emit_q;
      end
      if (wr_en) begin
        win_q[0] <= win_q[1];
        win_q[1] <= win_q[2];
        win_q[2] <= rd_up_k_q;
        win_q[3] <= win_q[4];
        win_q[4] <= win_q[5];
        win_q[5] <= rd_mid_q;
        win_q[6] <= win_q[7];
        win_q[7] <= win_q[8];
        win_q[8] <= s1_cmd_q.pixel;
      end
    end
  end

  assign gx_pos = {2'b00, win_q[2]} + {1'b0, win_q[5], 1'b0} + {2'b00, win_q[8]};
  assign gx_neg = {2'b00, win_q[0]} + {1'b0, win_q[3], 1'b0} + {2'b00, win_q[6]};
  assign gy_pos = {2'b00, win_q[6]} + {1'b0, win_q[7], 1'b0} + {2'b00, win_q[8]};
  assign gy_neg = {2'b00, win_q[0]} + {1'b0, win_q[1], 1'b0} + {2'b00, win_q[2]};
  assign gx = {1'b0, gx_pos} - {1'b0, gx_neg};
  assign gy = {1'b0, gy_pos} - {1'b0, gy_neg};
  assign gx_abs = gx[10] ? 10'(-gx) : gx[9:0];
  assign gy_abs = gy[10] ? 10'(-gy) : gy[9:0];
  assign mag = {1'b0, gx_abs} + {1'b0, gy_abs};
  assign is_edge = (mag > threshold_i);

  assign out_valid_o = out_valid_q;
  assign out_pixel_o = out_pixel_q;
  assign out_last_o = out_last_q;

endmodule

### rtl/sobel_edge_threshold.sv
`timescale 1ns / 1ps
// Top level of the streaming 3x3 Sobel edge detector with threshold.
// Holds the configuration registers; uses sobel_pkg, sobel_front, sobel_fifo, sobel_back.
//
//   Channel | Signals                                   | Direction
//   --------+-------------------------------------------+----------
//   cfg     | cfg_valid_i/ready_o, cfg_index_i, data_i  | in
//   in      | in_valid_i/ready_o, in_pixel_i, flush_i   | in
//   out     | out_valid_o/ready_i, out_pixel_o, last_o  | out
//
// One pixel transaction per clock is sustained while the output is not stalled;
// each command moves through the queue, the line buffer read stage, the window
// stage and the output register.
// Reset clears counters and the window; line buffers are not cleared.
// A stalled output freezes the datapath; a four-entry queue keeps the input
// side taking transactions until it fills.
module sobel_edge_threshold #(
  parameter int unsigned MAX_WIDTH  = sobel_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = sobel_pkg::MAX_HEIGHT_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [sobel_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [sobel_pkg::THR_W-1:0]     cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [sobel_pkg::PIX_W-1:0]     in_pixel_i,
  input  logic                            in_flush_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [sobel_pkg::PIX_W-1:0]     out_pixel_o,
  output logic                            out_last_o
);
  import sobel_pkg::*;

  localparam int unsigned CW = $clog2(MAX_WIDTH);
  localparam int unsigned QW = $bits(cmd_t) + 2 * CW;

  logic [THR_W-1:0] threshold_q;
  logic [DIM_W-1:0] width_q, height_q;

  logic          push, pop, empty, full;
  cmd_t          push_cmd, head_cmd;
  logic [CW-1:0] push_k, push_oaddr, head_k, head_oaddr;
  logic [QW-1:0] head_data;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q <= THR_RESET;
      width_q <= WIDTH_RESET;
      height_q <= HEIGHT_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_THRESHOLD: threshold_q <= cfg_data_i;
        CFG_WIDTH:     width_q <= cfg_data_i[DIM_W-1:0];
        CFG_HEIGHT:    height_q <= cfg_data_i[DIM_W-1:0];
        default: begin
        end
      endcase
    end
  end

  sobel_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_pixel_i  (in_pixel_i),
    .in_flush_i  (in_flush_i),
    .width_i     (width_q),
    .height_i    (height_q),
    .full_i      (full),
    .push_o      (push),
    .push_cmd_o  (push_cmd),
    .push_k_o    (push_k),
    .push_oaddr_o(push_oaddr)
  );

  sobel_fifo #(
    .DATA_W(QW),
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i ({push_cmd, push_k, push_oaddr}),
    .pop_i  (pop),
    .data_o (head_data),
    .empty_o(empty),
    .full_o (full)
  );

  assign {head_cmd, head_k, head_oaddr} = head_data;

  sobel_back #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .threshold_i (threshold_q),
    .empty_i     (empty),
    .pop_o       (pop),
    .head_cmd_i  (head_cmd),
    .head_k_i    (head_k),
    .head_oaddr_i(head_oaddr),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_pixel_o (out_pixel_o),
    .out_last_o  (out_last_o)
  );

endmodule

### rtl/sobel_chk.sv
`timescale 1ns / 1ps
// Port-level checks for sobel_edge_threshold, attached by a bind statement.
// Depends on sobel_pkg for field widths.
module sobel_chk (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_o,
  input logic                        out_valid_o,
  input logic                        out_ready_i,
  input logic [sobel_pkg::PIX_W-1:0] out_pixel_o,
  input logic                        out_last_o
);

  // A stalled result stays offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result withdrawn while stalled");

  // A stalled result keeps its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(out_pixel_o) && $stable(out_last_o))
    else $error("result payload changed while stalled");

  // The queue fills only through an accepted input transaction.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(in_ready_o) |-> $past(in_valid_i && in_ready_o))
    else $error("input side blocked without a new transaction");

  // With the output stalled the datapath is frozen, so a full queue stays full.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o && out_valid_o && !out_ready_i |=> !in_ready_o)
    else $error("queue drained while the output was stalled");

endmodule

bind sobel_edge_threshold sobel_chk u_sobel_chk (.*);

### tb/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for sobel_edge_threshold: streams frames under random pacing
// and checks each output transaction against a line-buffer predictor held in a class.
// Depends on sobel_pkg and the RTL of the block; reads no files.
module tb;
  import sobel_pkg::*;

  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned QUIET_CYCLES = 20;
  localparam int unsigned STALL_LIMIT = 4000;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             last;
  } px_result_t;

  typedef enum {PACE_FULL, PACE_SRC_IDLE, PACE_SINK_STALL, PACE_BOTH} pace_e;
  typedef enum {FILL_NOISE, FILL_FLAT, FILL_BINARY, FILL_RAMP} fill_e;
  typedef enum {SEAM_NONE, SEAM_PARTIAL, SEAM_FULL} seam_e;

  class sobel_tracker;
    logic [THR_W-1:0] thr;
    logic [DIM_W-1:0] wreg;
    logic [DIM_W-1:0] hreg;
    logic [PIX_W-1:0] upper_buf [MAX_WIDTH_DEF];
    logic [PIX_W-1:0] middle_buf [MAX_WIDTH_DEF];
    logic [PIX_W-1:0] win [9];
    int unsigned in_col, in_row, out_col, out_row, pending;
    px_result_t expected_q [$];
    int unsigned errors;

    function new();
      thr = THR_RESET;
      wreg = WIDTH_RESET;
      hreg = HEIGHT_RESET;
      foreach (upper_buf[i]) begin
        upper_buf[i] = '0;
        middle_buf[i] = '0;
      end
      foreach (win[i]) win[i] = '0;
      in_col = 0;
      in_row = 0;
      out_col = 0;
      out_row = 0;
      pending = 0;
      errors = 0;
    endfunction

    function int unsigned eff_width();
      if (wreg < MIN_DIM) return MIN_DIM;
      if (wreg > MAX_WIDTH_DEF) return MAX_WIDTH_DEF;
      return wreg;
    endfunction

    function int unsigned eff_height();
      if (hreg < MIN_DIM) return MIN_DIM;
      if (hreg > MAX_HEIGHT_DEF) return MAX_HEIGHT_DEF;
      return hreg;
    endfunction

    function int unsigned outstanding();
      return expected_q.size();
    endfunction

    function void write_reg(cfg_idx_e idx, logic [THR_W-1:0] data);
      case (idx)
        CFG_THRESHOLD: thr = data;
        CFG_WIDTH: wreg = data[DIM_W-1:0];
        CFG_HEIGHT: hreg = data[DIM_W-1:0];
        default: ;
      endcase
    endfunction

    function void post_result(logic [PIX_W-1:0] value, int unsigned w, int unsigned h);
      px_result_t res;
      res.pixel = value;
      res.last = (out_row >= h - 1) && (out_col >= w - 1);
      expected_q.push_back(res);
      if (res.last) begin
        out_col = 0;
        out_row = 0;
      end else if (out_col + 1 >= w) begin
        out_col = 0;
        out_row++;
      end else begin
        out_col++;
      end
    endfunction

    function void take_item(logic [PIX_W-1:0] px, logic fl);
      int unsigned w, h, k;
      logic at_start;
      logic [PIX_W-1:0] value;
      int gx, gy;
      w = eff_width();
      h = eff_height();
      at_start = (in_col == 0) && (in_row == 0);
      if (fl) begin
        if (pending == 0 || !at_start) return;
        k = out_col % MAX_WIDTH_DEF;
        value = (out_row >= h - 1) ? middle_buf[k] : upper_buf[k];
        pending--;
        post_result(value, w, h);
        return;
      end
      // A new frame after a partial drain drops the rest of the old tail.
      if (at_start && pending > 0 && pending < w + 1) begin
        pending = 0;
        out_col = 0;
        out_row = 0;
      end
      k = in_col % MAX_WIDTH_DEF;
      win[0] = win[1];
      win[1] = win[2];
      win[3] = win[4];
      win[4] = win[5];
      win[6] = win[7];
      win[7] = win[8];
      win[2] = upper_buf[k];
      win[5] = middle_buf[k];
      win[8] = px;
      upper_buf[k] = middle_buf[k];
      middle_buf[k] = px;
      if (in_col + 1 >= w) begin
        in_col = 0;
        in_row = (in_row + 1 >= h) ? 0 : in_row + 1;
      end else begin
        in_col++;
      end
      if (pending < w + 1) begin
        pending++;
        return;
      end
      if (out_row >= 1 && out_row + 2 <= h && out_col >= 1 && out_col + 2 <= w) begin
        gx = (int'(win[2]) + 2 * int'(win[5]) + int'(win[8]))
           - (int'(win[0]) + 2 * int'(win[3]) + int'(win[6]));
        gy = (int'(win[6]) + 2 * int'(win[7]) + int'(win[8]))
           - (int'(win[0]) + 2 * int'(win[1]) + int'(win[2]));
        if (gx < 0) gx = -gx;
        if (gy < 0) gy = -gy;
        value = (gx + gy > int'(thr)) ? PIX_EDGE : PIX_FLAT;
      end else begin
        value = upper_buf[out_col % MAX_WIDTH_DEF];
      end
      post_result(value, w, h);
    endfunction

    function void match_result(logic [PIX_W-1:0] px, logic last);
      px_result_t exp_res;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected output pixel %0d last %0b", $realtime, px, last);
        errors++;
        return;
      end
      exp_res = expected_q.pop_front();
      if (exp_res.pixel !== px) begin
        $display("%0t: out_pixel expected %0d actual %0d", $realtime, exp_res.pixel, px);
        errors++;
      end
      if (exp_res.last !== last) begin
        $display("%0t: out_last expected %0b actual %0b", $realtime, exp_res.last, last);
        errors++;
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  logic cfg_valid_i;
  logic cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [THR_W-1:0] cfg_data_i;
  logic in_valid_i;
  logic in_ready_o;
  logic [PIX_W-1:0] in_pixel_i;
  logic in_flush_i;
  logic out_valid_o;
  logic out_ready_i;
  logic [PIX_W-1:0] out_pixel_o;
  logic out_last_o;

  sobel_tracker tracker;
  pace_e pace;
  bit hold_request;
  int unsigned pixels_sent;
  int unsigned quiet_count;

  sobel_edge_threshold u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_pixel_i  (in_pixel_i),
    .in_flush_i  (in_flush_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_pixel_o (out_pixel_o),
    .out_last_o  (out_last_o)
  );

  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_request) begin
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_request = 1'b0;
      end
      if ((pace == PACE_SINK_STALL && $urandom_range(0, 99) < 57) ||
          (pace == PACE_BOTH && $urandom_range(0, 99) < 20)) begin
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) tracker.match_result(out_pixel_o, out_last_o);
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_count <= 0;
    end else if (quiet_count + 1 >= STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_count <= quiet_count + 1;
    end
  end

  task automatic write_cfg(input cfg_idx_e idx, input logic [THR_W-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    tracker.write_reg(idx, data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic push_item(input logic [PIX_W-1:0] px, input logic fl);
    @(negedge clk_i);
    while ((pace == PACE_SRC_IDLE && $urandom_range(0, 99) < 57) ||
           (pace == PACE_BOTH && $urandom_range(0, 99) < 20)) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_pixel_i <= px;
    in_flush_i <= fl;
    do @(posedge clk_i); while (!in_ready_o);
    tracker.take_item(px, fl);
  endtask

  task automatic drain(input int unsigned n);
    repeat (n) push_item(8'($urandom_range(0, 255)), 1'b1);
  endtask

  task automatic send_frame(input int unsigned w, input int unsigned h, input fill_e fill);
    logic [PIX_W-1:0] px;
    logic [PIX_W-1:0] base;
    base = 8'($urandom_range(0, 255));
    for (int unsigned r = 0; r < h; r++) begin
      for (int unsigned c = 0; c < w; c++) begin
        case (fill)
          FILL_NOISE: px = 8'($urandom_range(0, 255));
          FILL_FLAT: px = base + 8'($urandom_range(0, 6));
          FILL_BINARY: px = $urandom_range(0, 1) ? PIX_EDGE : PIX_FLAT;
          default: px = 8'(c * 37 + r * 11) + base;
        endcase
        if ((r != 0 || c != 0) && $urandom_range(0, 29) == 0) begin
          push_item(8'($urandom_range(0, 255)), 1'b1);
        end
        push_item(px, 1'b0);
        pixels_sent++;
      end
    end
  endtask

  task automatic finish_phase();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (tracker.outstanding() != 0) @(posedge clk_i);
    repeat (QUIET_CYCLES) @(posedge clk_i);
  endtask

  task automatic run_phase(input int unsigned phase);
    int unsigned w, h, nframes;
    logic [THR_W-1:0] thr;
    pace = pace_e'(phase % 4);
    case ($urandom_range(0, 5))
      0: thr = '0;
      1: thr = 11'd2040;
      2: thr = '1;
      default: thr = 11'($urandom_range(0, 700));
    endcase
    write_cfg(CFG_THRESHOLD, thr);
    write_cfg(CFG_WIDTH, {1'($urandom_range(0, 1)),
      10'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 12))});
    write_cfg(CFG_HEIGHT, {1'($urandom_range(0, 1)),
      10'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 6))});
    w = tracker.eff_width();
    h = tracker.eff_height();
    nframes = $urandom_range(1, 3);
    if (phase == 0) begin
      hold_request = 1'b1;
      nframes = 3;
    end
    for (int unsigned f = 0; f < nframes; f++) begin
      send_frame(w, h, fill_e'($urandom_range(0, 3)));
      if (f + 1 < nframes) begin
        case (seam_e'($urandom_range(0, 2)))
          SEAM_NONE: ;
          SEAM_PARTIAL: drain($urandom_range(1, w));
          default: drain(w + 1 + $urandom_range(0, 2));
        endcase
      end
    end
    drain(w + 1 + $urandom_range(0, 2));
    finish_phase();
  endtask

  // The frame is cut short after npix pixels; it ends the run.
  task automatic run_extreme(input logic [THR_W-1:0] wdata, input logic [THR_W-1:0] hdata,
                             input pace_e p, input int unsigned npix);
    pace = p;
    write_cfg(CFG_THRESHOLD, 11'($urandom_range(0, 700)));
    write_cfg(CFG_WIDTH, wdata);
    write_cfg(CFG_HEIGHT, hdata);
    repeat (npix) begin
      push_item(8'($urandom_range(0, 255)), 1'b0);
      pixels_sent++;
    end
    finish_phase();
  endtask

  initial begin
    int unsigned phase;
    tracker = new();
    pace = PACE_FULL;
    hold_request = 1'b0;
    pixels_sent = 0;
    quiet_count = 0;
    rst_ni = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = CFG_THRESHOLD;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    in_pixel_i = '0;
    in_flush_i = 1'b0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    write_cfg(CFG_THRESHOLD, '0);
    write_cfg(CFG_WIDTH, 11'd1);
    write_cfg(CFG_HEIGHT, 11'd2);
    push_item(8'hA5, 1'b1);
    push_item(8'h00, 1'b0);
    push_item(8'h00, 1'b0);
    push_item(8'hFF, 1'b0);
    push_item(8'h00, 1'b0);
    push_item(8'h5A, 1'b1);
    push_item(8'h00, 1'b0);
    push_item(8'hFF, 1'b0);
    push_item(8'h00, 1'b0);
    push_item(8'h00, 1'b0);
    push_item(8'hFF, 1'b0);
    drain(5);
    finish_phase();

    phase = 0;
    pixels_sent = 0;
    while (pixels_sent < 400) begin
      run_phase(phase);
      phase++;
    end
    run_extreme(11'h7FF, 11'd0, PACE_BOTH, 560);

    if (tracker.errors == 0 && tracker.outstanding() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule

### files.f
rtl/sobel_pkg.sv
rtl/sobel_front.sv
rtl/sobel_fifo.sv
rtl/sobel_back.sv
rtl/sobel_edge_threshold.sv
rtl/sobel_chk.sv
tb/tb.sv
